### design/acis_pkg.sv
// Package: shared types and constants for the accumulator CPU instruction step block.
package acis_pkg;

    localparam int StackDepth = 8;
    localparam int SpBits = $clog2(StackDepth);
    localparam int PcBits = 14;

    typedef struct packed {
        logic [7:0] op;
        logic [7:0] imm_low;
        logic [7:0] imm_high;
        logic [7:0] mem_read_data;
        logic [7:0] io_read_data;
        logic       from_interrupt;
    } instr_t;

    typedef struct packed {
        logic [13:0] next_pc;
        logic [15:0] mem_address;
        logic        mem_write;
        logic [7:0]  mem_write_data;
        logic [1:0]  io_access;
        logic [4:0]  io_port;
        logic [7:0]  io_write_data;
        logic [7:0]  accumulator;
        logic [3:0]  flag_bits;
        logic        halted;
        logic        illegal_op;
        logic [3:0]  cycles;
    } result_t;

    typedef enum logic [3:0] {
        CLS_HALT, CLS_MOV, CLS_INCDEC, CLS_ILLEGAL, CLS_ROT, CLS_RETC, CLS_ALUI,
        CLS_RST, CLS_MVI, CLS_RET, CLS_JCC, CLS_JMP, CLS_CALL, CLS_IO, CLS_ALUR
    } cls_t;

    typedef struct packed {
        instr_t     ins;
        cls_t       cls;
    } decoded_t;

    localparam logic [1:0] IO_NONE = 2'd0;
    localparam logic [1:0] IO_IN   = 2'd1;
    localparam logic [1:0] IO_OUT  = 2'd2;

endpackage

### design/acis_front.sv
// Front end: accepts instructions and classifies the opcode.
module acis_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  acis_pkg::instr_t  ins,
    output logic              dec_valid,
    input  logic              dec_ready,
    output acis_pkg::decoded_t dec
);
    logic [2:0] dst;
    logic [2:0] src;
    acis_pkg::cls_t cls;

    assign dst = ins.op[5:3];
    assign src = ins.op[2:0];

    always_comb
    begin
        cls = acis_pkg::CLS_ALUR;
        unique case (ins.op[7:6])
            2'd3:
                cls = (ins.op == 8'hff) ? acis_pkg::CLS_HALT : acis_pkg::CLS_MOV;
            2'd0:
                unique case (src)
                    3'd0, 3'd1:
                        cls = (dst == 3'd0) ? acis_pkg::CLS_HALT :
                              (dst == 3'd7) ? acis_pkg::CLS_ILLEGAL : acis_pkg::CLS_INCDEC;
                    3'd2: cls = dst[2] ? acis_pkg::CLS_ILLEGAL : acis_pkg::CLS_ROT;
                    3'd3: cls = acis_pkg::CLS_RETC;
                    3'd4: cls = acis_pkg::CLS_ALUI;
                    3'd5: cls = acis_pkg::CLS_RST;
                    3'd6: cls = acis_pkg::CLS_MVI;
                    default: cls = acis_pkg::CLS_RET;
                endcase
            2'd1:
                unique case (src)
                    3'd0, 3'd2: cls = acis_pkg::CLS_JCC;
                    3'd4: cls = acis_pkg::CLS_JMP;
                    3'd6: cls = acis_pkg::CLS_CALL;
                    default: cls = acis_pkg::CLS_IO;
                endcase
            default: cls = acis_pkg::CLS_ALUR;
        endcase
    end

    assign in_ready = !dec_valid || dec_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_valid <= 1'b0;
        end
        else if (in_ready)
        begin
            dec_valid <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            dec.ins <= ins;
            dec.cls <= cls;
        end
    end
endmodule

### design/acis_queue.sv
// Two-entry queue between the front end and the execute stage.
module acis_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_valid,
    output logic               wr_ready,
    input  acis_pkg::decoded_t wr_data,
    output logic               rd_valid,
    input  logic               rd_ready,
    output acis_pkg::decoded_t rd_data
);
    acis_pkg::decoded_t mem_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem_reg[rptr_reg];
    assign push = wr_valid && wr_ready;
    assign pop  = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end
endmodule

### design/acis_exec.sv
// Execute stage: architectural state, ALU, stack and result register.
module acis_exec
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  acis_pkg::decoded_t dec,
    output logic               res_valid,
    input  logic               res_ready,
    output acis_pkg::result_t  res
);
    localparam logic [acis_pkg::SpBits-1:0] SpMax = acis_pkg::SpBits'(acis_pkg::StackDepth - 1);

    logic [7:0] rf_reg [7];
    logic [7:0] rf_next [7];
    logic [acis_pkg::PcBits-1:0] stk_reg [acis_pkg::StackDepth];
    logic [acis_pkg::PcBits-1:0] stk_next [acis_pkg::StackDepth];
    logic [acis_pkg::SpBits-1:0] sp_reg, sp_next;
    logic cy_reg, z_reg, s_reg, p_reg, hlt_reg;
    logic cy_next, z_next, s_next, p_next, hlt_next;
    acis_pkg::result_t r;
    logic fire;

    logic [7:0] op;
    logic [2:0] dst, src;
    logic [acis_pkg::PcBits-1:0] pc, target;
    logic [7:0] a, v, srcv;
    logic [8:0] t;
    logic cond;
    logic [acis_pkg::SpBits-1:0] sp_dn, sp_up;

    assign in_ready = !res_valid || res_ready;
    assign fire = in_valid && in_ready;
    assign op  = dec.ins.op;
    assign dst = op[5:3];
    assign src = op[2:0];
    assign a   = rf_reg[0];
    assign srcv = (src == 3'd7) ? dec.ins.mem_read_data : rf_reg[src];
    assign target = acis_pkg::PcBits'({dec.ins.imm_high[5:0], dec.ins.imm_low});
    assign sp_up = (sp_reg == SpMax) ? '0 : sp_reg + 1'b1;
    assign sp_dn = (sp_reg == '0) ? SpMax : sp_reg - 1'b1;

    always_comb
    begin
        unique case (op[4:3])
            2'd0: cond = (cy_reg == op[5]);
            2'd1: cond = (z_reg == op[5]);
            2'd2: cond = (s_reg == op[5]);
            default: cond = (p_reg == op[5]);
        endcase
    end

    always_comb
    begin
        logic [7:0] b;
        logic [2:0] sel;
        logic       do_alu;
        logic       do_zsp;
        logic [7:0] zv;
        rf_next  = rf_reg;
        stk_next = stk_reg;
        sp_next  = sp_reg;
        cy_next = cy_reg; z_next = z_reg; s_next = s_reg; p_next = p_reg;
        hlt_next = hlt_reg;
        r = '0;
        b = srcv;
        sel = dst;
        do_alu = 1'b0;
        do_zsp = 1'b0;
        zv = '0;
        t = '0;
        v = '0;
        pc = stk_reg[sp_reg];
        if (dec.ins.from_interrupt)
        begin
            if (hlt_reg)
            begin
                pc = pc + 1'b1;
                hlt_next = 1'b0;
            end
        end
        else
        begin
            pc = pc + 1'b1;
        end
        r.mem_address = {rf_reg[5], rf_reg[6]};
        unique case (dec.cls)
            acis_pkg::CLS_HALT:
            begin
                r.cycles = 4'd4; pc = pc - 1'b1; hlt_next = 1'b1;
            end
            acis_pkg::CLS_MOV:
            begin
                r.cycles = 4'd5 + ((dst == 3'd7) ? 4'd2 : 4'd0) + ((src == 3'd7) ? 4'd3 : 4'd0);
                if (dst == 3'd7)
                begin
                    r.mem_write = 1'b1; r.mem_write_data = srcv;
                end
                else
                begin
                    rf_next[dst] = srcv;
                end
            end
            acis_pkg::CLS_INCDEC:
            begin
                r.cycles = 4'd5;
                v = src[0] ? rf_reg[dst] - 1'b1 : rf_reg[dst] + 1'b1;
                rf_next[dst] = v;
                do_zsp = 1'b1; zv = v;
            end
            acis_pkg::CLS_ILLEGAL:
            begin
                r.cycles = 4'd5; r.illegal_op = 1'b1;
            end
            acis_pkg::CLS_ROT:
            begin
                r.cycles = 4'd5;
                unique case (dst[1:0])
                    2'd0: begin rf_next[0] = {a[6:0], a[7]}; cy_next = a[7]; end
                    2'd1: begin rf_next[0] = {a[0], a[7:1]}; cy_next = a[0]; end
                    2'd2: begin rf_next[0] = {a[6:0], cy_reg}; cy_next = a[7]; end
                    default: begin rf_next[0] = {cy_reg, a[7:1]}; cy_next = a[0]; end
                endcase
            end
            acis_pkg::CLS_RETC:
            begin
                r.cycles = 4'd3;
                if (cond)
                begin
                    r.cycles = 4'd5;
                    stk_next[sp_reg] = '0; sp_next = sp_dn; pc = stk_reg[sp_dn];
                end
            end
            acis_pkg::CLS_RET:
            begin
                r.cycles = 4'd5;
                stk_next[sp_reg] = '0; sp_next = sp_dn; pc = stk_reg[sp_dn];
            end
            acis_pkg::CLS_ALUI:
            begin
                r.cycles = 4'd8; pc = pc + 1'b1;
                b = dec.ins.imm_low; do_alu = 1'b1;
            end
            acis_pkg::CLS_RST:
            begin
                r.cycles = 4'd5;
                stk_next[sp_reg] = pc; sp_next = sp_up;
                pc = acis_pkg::PcBits'(op & 8'h38);
            end
            acis_pkg::CLS_MVI:
            begin
                r.cycles = (dst == 3'd7) ? 4'd9 : 4'd8; pc = pc + 1'b1;
                if (dst == 3'd7)
                begin
                    r.mem_write = 1'b1; r.mem_write_data = dec.ins.imm_low;
                end
                else
                begin
                    rf_next[dst] = dec.ins.imm_low;
                end
            end
            acis_pkg::CLS_JCC:
            begin
                r.cycles = 4'd9; pc = pc + 2'd2;
                if (cond)
                begin
                    r.cycles = 4'd11;
                    if (src == 3'd2)
                    begin
                        stk_next[sp_reg] = pc; sp_next = sp_up;
                    end
                    pc = target;
                end
            end
            acis_pkg::CLS_JMP:
            begin
                r.cycles = 4'd11; pc = target;
            end
            acis_pkg::CLS_CALL:
            begin
                r.cycles = 4'd11; pc = pc + 2'd2;
                stk_next[sp_reg] = pc; sp_next = sp_up; pc = target;
            end
            acis_pkg::CLS_IO:
            begin
                r.io_port = op[5:1];
                if (op[5:4] == 2'd0)
                begin
                    r.cycles = 4'd8; r.io_access = acis_pkg::IO_IN;
                    rf_next[0] = dec.ins.io_read_data;
                end
                else
                begin
                    r.cycles = 4'd6; r.io_access = acis_pkg::IO_OUT;
                    r.io_write_data = a;
                end
            end
            default:
            begin
                r.cycles = (src == 3'd7) ? 4'd8 : 4'd5;
                do_alu = 1'b1;
            end
        endcase
        if (do_alu)
        begin
            unique case (sel)
                3'd0: t = {1'b0, a} + {1'b0, b};
                3'd1: t = {1'b0, a} + {1'b0, b} + {8'd0, cy_reg};
                3'd2, 3'd7: t = {1'b0, a} - {1'b0, b};
                3'd3: t = {1'b0, a} - {1'b0, b} - {8'd0, cy_reg};
                3'd4: t = {1'b0, a & b};
                3'd5: t = {1'b0, a ^ b};
                default: t = {1'b0, a | b};
            endcase
            cy_next = t[8];
            if (sel != 3'd7)
            begin
                rf_next[0] = t[7:0];
            end
            do_zsp = 1'b1; zv = t[7:0];
        end
        if (do_zsp)
        begin
            z_next = (zv == 8'd0);
            s_next = zv[7];
            p_next = ~^zv;
        end
        stk_next[sp_next] = pc;
        r.next_pc     = 14'(stk_next[sp_next]);
        r.accumulator = rf_next[0];
        r.flag_bits   = {p_next, s_next, z_next, cy_next};
        r.halted      = hlt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 7; i++)
            begin
                rf_reg[i] <= '0;
            end
            for (int i = 0; i < acis_pkg::StackDepth; i++)
            begin
                stk_reg[i] <= '0;
            end
            sp_reg <= '0;
            cy_reg <= 1'b0; z_reg <= 1'b0; s_reg <= 1'b0; p_reg <= 1'b0;
            hlt_reg <= 1'b0;
            res_valid <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                res_valid <= in_valid;
            end
            if (fire)
            begin
                rf_reg <= rf_next;
                stk_reg <= stk_next;
                sp_reg <= sp_next;
                cy_reg <= cy_next; z_reg <= z_next; s_reg <= s_next; p_reg <= p_next;
                hlt_reg <= hlt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res <= r;
        end
    end
endmodule

### design/accumulator_cpu_instruction_step.sv
// Top level of the accumulator CPU instruction step block.
// Executes one instruction per input transaction and returns one result transaction.
// Input channel: in_valid/in_ready with op, immediate bytes, memory and port read
// data and the interrupt marker. Output channel: out_valid/out_ready with the new
// PC, memory and port accesses, accumulator, flags, halt, illegal marker, cycles.
// Path: decode register, two-entry queue, execute stage with result register.
// Throughput is one instruction per cycle while out_ready is high; the execute stage
// updates registers, flags and the return stack with the edge that loads its result register.
// Reset clears registers, flags, stack, stack pointer, halt and all valids.
// When the receiver stalls, the result register holds, the queue fills and
// in_ready drops once the queue and decode register are full; no transaction is lost.
module accumulator_cpu_instruction_step
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  op,
    input  logic [7:0]  imm_low,
    input  logic [7:0]  imm_high,
    input  logic [7:0]  mem_read_data,
    input  logic [7:0]  io_read_data,
    input  logic        from_interrupt,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [13:0] next_pc,
    output logic [15:0] mem_address,
    output logic        mem_write,
    output logic [7:0]  mem_write_data,
    output logic [1:0]  io_access,
    output logic [4:0]  io_port,
    output logic [7:0]  io_write_data,
    output logic [7:0]  accumulator,
    output logic [3:0]  flag_bits,
    output logic        halted,
    output logic        illegal_op,
    output logic [3:0]  cycles
);
    acis_pkg::instr_t   ins;
    acis_pkg::decoded_t f_dec, q_dec;
    acis_pkg::result_t  res;
    logic f_valid, f_ready, q_valid, q_ready;

    assign ins = '{op: op, imm_low: imm_low, imm_high: imm_high,
                   mem_read_data: mem_read_data, io_read_data: io_read_data,
                   from_interrupt: from_interrupt};

    acis_front u_front
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .ins(ins),
        .dec_valid(f_valid), .dec_ready(f_ready), .dec(f_dec)
    );

    acis_queue u_queue
    (
        .clk(clk), .rst_n(rst_n), .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_dec),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_dec)
    );

    acis_exec u_exec
    (
        .clk(clk), .rst_n(rst_n), .in_valid(q_valid), .in_ready(q_ready), .dec(q_dec),
        .res_valid(out_valid), .res_ready(out_ready), .res(res)
    );

    assign next_pc        = res.next_pc;
    assign mem_address    = res.mem_address;
    assign mem_write      = res.mem_write;
    assign mem_write_data = res.mem_write_data;
    assign io_access      = res.io_access;
    assign io_port        = res.io_port;
    assign io_write_data  = res.io_write_data;
    assign accumulator    = res.accumulator;
    assign flag_bits      = res.flag_bits;
    assign halted         = res.halted;
    assign illegal_op     = res.illegal_op;
    assign cycles         = res.cycles;
endmodule

### design/acis_checker.sv
// Port-level checker for the accumulator CPU instruction step block.
module acis_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        mem_write,
    input logic [7:0]  mem_write_data,
    input logic [1:0]  io_access,
    input logic [4:0]  io_port,
    input logic [7:0]  io_write_data,
    input logic        illegal_op,
    input logic [3:0]  cycles
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cycles))
        else $error("result changed while stalled");
    a_io_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> io_access != 2'd3) else $error("bad io code");
    a_io_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && io_access == 2'd0 |-> io_port == 5'd0 && io_write_data == 8'd0)
        else $error("stray io fields");
    a_mem_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !mem_write |-> mem_write_data == 8'd0)
        else $error("stray write data");
    a_illegal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && illegal_op |-> cycles == 4'd5 && !mem_write && io_access == 2'd0)
        else $error("illegal op had effects");
endmodule

bind accumulator_cpu_instruction_step acis_checker u_acis_checker
(
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .mem_write(mem_write), .mem_write_data(mem_write_data), .io_access(io_access),
    .io_port(io_port), .io_write_data(io_write_data), .illegal_op(illegal_op),
    .cycles(cycles)
);
